/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the pixel decorrelation block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BGRD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed: lbl");
`define BGRD_ASSERT_RESET(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) (!(rstn)) |=> (prop)) \
        else $error("reset assertion failed: lbl");
`else
`define BGRD_ASSERT(lbl, clk, rstn, prop)
`define BGRD_ASSERT_RESET(lbl, clk, rstn, prop)
`endif
`endif

/* hdl/bgrd_pkg.sv */
// ---------------------------------------------------------------------------
// Decorrelation package
// Shared sizes, register indexes and control types for the block.
// ---------------------------------------------------------------------------
package bgrd_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 13;
    localparam int NUM_LANES = 4;
    localparam int CFG_IDX_W = 2;

    typedef logic [7:0] pix_byte_t;
    typedef logic [NUM_LANES-1:0][7:0] pix_word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION    = 2'd0,
        CFG_PIXEL_FORMAT = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic decode;
        logic four_chan;
    } xform_ctl_t;

endpackage

/* hdl/bgrd_lane.sv */
// ---------------------------------------------------------------------------
// Channel lane
// Two-dimensional delta prediction for one byte channel of a pixel.
// ---------------------------------------------------------------------------
module bgrd_lane
    import bgrd_pkg::*;
(
    input  xform_ctl_t ctl,
    input  pix_byte_t  din,
    input  pix_byte_t  left_px,
    input  pix_byte_t  above_px,
    input  pix_byte_t  upleft_px,
    output pix_byte_t  c_out,
    output pix_byte_t  res_out
);

    pix_byte_t pred;

    assign pred = left_px + above_px - upleft_px;

    always_comb begin
        if (ctl.decode) begin
            c_out   = din + pred;
            res_out = c_out;
        end else begin
            c_out   = din;
            res_out = din - pred;
        end
    end

endmodule

/* hdl/bgrd_merge.sv */
// ---------------------------------------------------------------------------
// Lane merge
// Combines the lane results, restores green on decode and masks the
// fourth channel in three-channel mode.
// ---------------------------------------------------------------------------
module bgrd_merge
    import bgrd_pkg::*;
(
    input  xform_ctl_t ctl,
    input  pix_word_t  lane_c,
    input  pix_word_t  lane_res,
    output pix_word_t  pix_out,
    output pix_word_t  c_word
);

    always_comb begin
        pix_out = lane_res;
        if (ctl.decode) begin
            pix_out[0] = lane_res[0] + lane_res[1];
            pix_out[2] = lane_res[2] + lane_res[1];
        end
        c_word = lane_c;
        if (!ctl.four_chan) begin
            pix_out[3] = '0;
            c_word[3]  = '0;
        end
    end

endmodule

/* hdl/bgrd_line_buf.sv */
// ---------------------------------------------------------------------------
// Line buffer
// One-row store of decorrelated pixels with a registered read port.
// ---------------------------------------------------------------------------
module bgrd_line_buf
    import bgrd_pkg::*;
(
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  pix_word_t        wr_data,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output pix_word_t        rd_data
);

    pix_word_t mem [MAX_WIDTH];
    pix_word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/bgr_decorrelate_2d_delta.sv */
// An accepted item is registered in the compute stage and then in the result
// register, which drives the result port.
// Throughput: one item per cycle unless m_ready stalls; the single line buffer
// is read once at acceptance and written once when the item leaves the compute stage.
// Reset: aresetn is synchronous, active low; it clears the registers, the
// stream position and both pipeline stages. The line buffer is not cleared.
// ---------------------------------------------------------------------------
// Subtract-green decorrelation with two-dimensional delta prediction
// Raster pixel stream, four byte lanes, line buffer for the upper row.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bgr_decorrelate_2d_delta
    import bgrd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH_W-1:0]   cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_chan_0,
    input  logic [7:0]           s_chan_1,
    input  logic [7:0]           s_chan_2,
    input  logic [7:0]           s_chan_3,
    input  logic                 s_chunk_start,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_0,
    output logic [7:0]           m_out_1,
    output logic [7:0]           m_out_2,
    output logic [7:0]           m_out_3,
    output logic                 m_row_end
);

    logic               direction_reg;
    logic               pixel_format_reg;
    logic [WIDTH_W-1:0] image_width_reg;

    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic               top_reg;
    logic               top_next;

    logic               s1_valid_reg;
    pix_word_t          s1_px_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic               s1_first_reg;
    logic               s1_top_reg;
    logic               s1_last_reg;
    logic               s1_byp_reg;
    pix_word_t          byp_reg;

    pix_word_t          left_reg;
    pix_word_t          ul_reg;

    logic               m_valid_reg;
    pix_word_t          m_pix_reg;
    logic               m_row_end_reg;

    logic               accept;
    logic               s1_fire;
    logic [COL_W-1:0]   col_cur;
    logic               top_cur;
    logic [WIDTH_W-1:0] eff_width;
    logic [WIDTH_W-1:0] col_plus;
    logic               last_cur;

    xform_ctl_t         ctl;
    pix_word_t          mem_rdata;
    pix_word_t          above_w;
    pix_word_t          left_w;
    pix_word_t          ul_w;
    pix_word_t          lane_din;
    pix_word_t          lane_c;
    pix_word_t          lane_res;
    pix_word_t          pix_out;
    pix_word_t          c_word;

    assign ctl.decode    = direction_reg;
    assign ctl.four_chan = pixel_format_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg    <= 1'b0;
            pixel_format_reg <= 1'b0;
            image_width_reg  <= WIDTH_W'(4);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DIRECTION:    direction_reg    <= cfg_wdata[0];
                CFG_PIXEL_FORMAT: pixel_format_reg <= cfg_wdata[0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stream position for the item being accepted.
    always_comb begin
        if (image_width_reg == '0) begin
            eff_width = WIDTH_W'(1);
        end else if (image_width_reg > WIDTH_W'(MAX_WIDTH)) begin
            eff_width = WIDTH_W'(MAX_WIDTH);
        end else begin
            eff_width = image_width_reg;
        end
        col_cur  = s_chunk_start ? '0 : col_reg;
        top_cur  = s_chunk_start ? 1'b1 : top_reg;
        col_plus = WIDTH_W'(col_cur) + WIDTH_W'(1);
        last_cur = (col_plus >= eff_width);
        col_next = last_cur ? '0 : col_plus[COL_W-1:0];
        top_next = last_cur ? 1'b0 : top_cur;
    end

    assign s1_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_fire;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            top_reg      <= 1'b1;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                top_reg <= top_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // When the item leaving the compute stage writes the column the new item reads, its result is bypassed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_px_reg    <= {s_chan_3, s_chan_2, s_chan_1, s_chan_0};
            s1_col_reg   <= col_cur;
            s1_first_reg <= (col_cur == '0);
            s1_top_reg   <= top_cur;
            s1_last_reg  <= last_cur;
            s1_byp_reg   <= s1_fire && (s1_col_reg == col_cur);
            byp_reg      <= c_word;
        end
    end

    bgrd_line_buf u_line_buf (
        .aclk    (aclk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (c_word),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (mem_rdata)
    );

    always_comb begin
        above_w  = s1_top_reg ? '0 : (s1_byp_reg ? byp_reg : mem_rdata);
        left_w   = s1_first_reg ? '0 : left_reg;
        ul_w     = (s1_first_reg || s1_top_reg) ? '0 : ul_reg;
        lane_din = s1_px_reg;
        if (!ctl.decode) begin
            lane_din[0] = s1_px_reg[0] - s1_px_reg[1];
            lane_din[2] = s1_px_reg[2] - s1_px_reg[1];
        end
        if (!ctl.four_chan) begin
            lane_din[3] = '0;
        end
    end

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        bgrd_lane u_lane (
            .ctl       (ctl),
            .din       (lane_din[k]),
            .left_px   (left_w[k]),
            .above_px  (above_w[k]),
            .upleft_px (ul_w[k]),
            .c_out     (lane_c[k]),
            .res_out   (lane_res[k])
        );
    end

    bgrd_merge u_merge (
        .ctl      (ctl),
        .lane_c   (lane_c),
        .lane_res (lane_res),
        .pix_out  (pix_out),
        .c_word   (c_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg    <= '0;
            ul_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s1_fire) begin
                left_reg    <= c_word;
                ul_reg      <= above_w;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_pix_reg     <= pix_out;
            m_row_end_reg <= s1_last_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_out_0   = m_pix_reg[0];
    assign m_out_1   = m_pix_reg[1];
    assign m_out_2   = m_pix_reg[2];
    assign m_out_3   = m_pix_reg[3];
    assign m_row_end = m_row_end_reg;

    `BGRD_ASSERT_RESET(a_reset_empty, aclk, aresetn, !m_valid_reg && !s1_valid_reg)
    `BGRD_ASSERT(a_row_wrap, aclk, aresetn, accept && last_cur |=> col_reg == '0 && !top_reg)
    `BGRD_ASSERT(a_bypass_src, aclk, aresetn, accept && s1_fire && (s1_col_reg == col_cur) |=> s1_byp_reg)
    `BGRD_ASSERT(a_col_step, aclk, aresetn, accept && !last_cur |=> col_reg == $past(col_next))

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the subtract-green two-dimensional delta block
// Streams raster pixels through the block in both directions and both pixel
// formats at many row widths, with random stalls on either channel. Each
// accepted pixel is run through an internal predictor of the transform, and every
// result item is checked field by field against the oldest expected value.
// ---------------------------------------------------------------------------
module tb_top;
    import bgrd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 10;
    localparam int NUM_PHASES  = 18;
    localparam int BIG_PHASE   = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        pix_word_t bytes;
        logic      row_end;
    } pixel_result_t;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [WIDTH_W-1:0]   reg_data;
        pix_word_t            chans;
        logic                 chunk;
        logic                 typed;
        pixel_result_t        want;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WIDTH_W-1:0]   cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_chan_0;
    logic [7:0]           s_chan_1;
    logic [7:0]           s_chan_2;
    logic [7:0]           s_chan_3;
    logic                 s_chunk_start;
    logic                 m_valid;
    logic                 m_ready;
    logic [7:0]           m_out_0;
    logic [7:0]           m_out_1;
    logic [7:0]           m_out_2;
    logic [7:0]           m_out_3;
    logic                 m_row_end;

    // Predictor state: the reconstructed upper row and the stream position.
    pix_word_t          upper_row [MAX_WIDTH];
    bit                 upper_row_set [MAX_WIDTH];
    pix_word_t          left_word;
    pix_word_t          upper_left_word;
    int                 col_pos;
    bit                 top_row;
    bit                 cfg_decode;
    bit                 cfg_four_chan;
    logic [WIDTH_W-1:0] cfg_width;

    pixel_result_t expected_pixels [$];
    stim_row_t     directed_rows [$];
    int            err_count = 0;
    int            cycle_count = 0;
    bit            idle_on;
    logic          typed_pending;
    pixel_result_t typed_want;

    bgr_decorrelate_2d_delta DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic pixel_result_t predict_delta_pixel(input pix_word_t chans,
                                                          input logic chunk);
        pix_word_t     px;
        pix_word_t     c;
        pix_word_t     above;
        pix_word_t     lft;
        pix_word_t     ul;
        pixel_result_t r;
        int            eff_width;
        int            k;
        eff_width = (cfg_width == 0) ? 1 :
                    ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
        px = chans;
        if (!cfg_four_chan) begin
            px[3] = 8'h00;
        end
        if (chunk) begin
            col_pos = 0;
            top_row = 1'b1;
        end
        if (col_pos >= MAX_WIDTH) begin
            col_pos = 0;
        end
        above = top_row ? '0 : upper_row[col_pos];
        lft   = (col_pos == 0) ? '0 : left_word;
        ul    = (col_pos == 0 || top_row) ? '0 : upper_left_word;
        if (!cfg_decode) begin
            c[0] = px[0] - px[1];
            c[1] = px[1];
            c[2] = px[2] - px[1];
            c[3] = px[3];
            for (k = 0; k < NUM_LANES; k++) begin
                r.bytes[k] = c[k] - lft[k] - above[k] + ul[k];
            end
        end else begin
            for (k = 0; k < NUM_LANES; k++) begin
                c[k] = px[k] + lft[k] + above[k] - ul[k];
            end
            r.bytes[0] = c[0] + c[1];
            r.bytes[1] = c[1];
            r.bytes[2] = c[2] + c[1];
            r.bytes[3] = c[3];
        end
        if (!cfg_four_chan) begin
            r.bytes[3] = 8'h00;
            c[3] = 8'h00;
        end
        upper_left_word = above;
        left_word = c;
        upper_row[col_pos] = c;
        upper_row_set[col_pos] = 1'b1;
        r.row_end = (col_pos + 1 >= eff_width);
        if (r.row_end) begin
            col_pos = 0;
            top_row = 1'b0;
        end else begin
            col_pos++;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        pixel_result_t want;
        pixel_result_t got;
        if (!aresetn) begin
            col_pos = 0;
            top_row = 1'b1;
            left_word = '0;
            upper_left_word = '0;
            cfg_decode = 1'b0;
            cfg_four_chan = 1'b0;
            cfg_width = 13'd4;
            foreach (upper_row_set[i]) upper_row_set[i] = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.bytes = {m_out_3, m_out_2, m_out_1, m_out_0};
                got.row_end = m_row_end;
                if (expected_pixels.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("Unexpected result item: out %h row_end %b",
                                 got.bytes, got.row_end);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.bytes[0] !== want.bytes[0] || got.bytes[1] !== want.bytes[1] ||
                        got.bytes[2] !== want.bytes[2] || got.bytes[3] !== want.bytes[3] ||
                        got.row_end !== want.row_end) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("Mismatch: exp %h %h %h %h re %b, got %h %h %h %h re %b",
                                     want.bytes[0], want.bytes[1], want.bytes[2],
                                     want.bytes[3], want.row_end, got.bytes[0],
                                     got.bytes[1], got.bytes[2], got.bytes[3],
                                     got.row_end);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = predict_delta_pixel({s_chan_3, s_chan_2, s_chan_1, s_chan_0},
                                           s_chunk_start);
                expected_pixels.push_back(typed_pending ? typed_want : want);
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DIRECTION: begin
                        cfg_decode = cfg_wdata[0];
                    end
                    CFG_PIXEL_FORMAT: begin
                        cfg_four_chan = cfg_wdata[0];
                    end
                    CFG_IMAGE_WIDTH: begin
                        cfg_width = cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        m_ready = 1'b1;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    function automatic void add_pixel_row(input pix_word_t chans, input logic chunk,
                                          input logic typed, input pixel_result_t want);
        stim_row_t row;
        row = '0;
        row.chans = chans;
        row.chunk = chunk;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [WIDTH_W-1:0] data);
        stim_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_data = data;
        directed_rows.push_back(row);
    endfunction

    // A pixel that would read a never-written column of the upper row is sent
    // as a chunk start instead, so that only stored rows are ever predicted.
    task automatic send_pixel(input pix_word_t chans, input logic chunk,
                              input logic typed, input pixel_result_t want);
        logic chunk_eff;
        chunk_eff = chunk;
        if (!chunk && !top_row && !upper_row_set[col_pos]) begin
            chunk_eff = 1'b1;
        end
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_chan_0 <= chans[0];
        s_chan_1 <= chans[1];
        s_chan_2 <= chans[2];
        s_chan_3 <= chans[3];
        s_chunk_start <= chunk_eff;
        typed_pending <= typed;
        typed_want <= want;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [WIDTH_W-1:0] data);
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        stim_row_t row;
        pix_word_t chans;
        logic      chunk;
        int        n_items;
        int        pick;
        int        phase;
        int        i;
        int        k;

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_DIRECTION;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_chan_0 = 8'h00;
        s_chan_1 = 8'h00;
        s_chan_2 = 8'h00;
        s_chan_3 = 8'h00;
        s_chunk_start = 1'b0;
        typed_pending = 1'b0;
        typed_want = '0;
        idle_on = 1'b1;

        // Encode, three channels, width four: the first row is easy to work by hand.
        add_pixel_row(32'hFFFFFFFF, 1'b1, 1'b1, {32'h0000FF00, 1'b0});
        add_pixel_row(32'h00000000, 1'b0, 1'b1, {32'h00000100, 1'b0});
        add_pixel_row(32'h80808080, 1'b0, 1'b1, {32'h00008000, 1'b0});
        add_pixel_row(32'hAAFF0001, 1'b0, 1'b1, {32'h00FF8001, 1'b1});
        add_pixel_row(32'h40302010, 1'b0, 1'b0, '0);
        add_pixel_row(32'h00FF00FF, 1'b0, 1'b0, '0);
        add_pixel_row(32'hC3A55A3C, 1'b0, 1'b0, '0);
        add_cfg_row(CFG_PIXEL_FORMAT, 13'd1);
        add_pixel_row(32'hFF000000, 1'b0, 1'b0, '0);
        add_pixel_row(32'h7F80017E, 1'b0, 1'b0, '0);
        add_cfg_row(CFG_UNMAPPED, 13'h1FFF);
        add_cfg_row(CFG_DIRECTION, 13'd1);
        add_pixel_row(32'h12345678, 1'b0, 1'b0, '0);
        add_pixel_row(32'hFEDCBA98, 1'b1, 1'b0, '0);
        add_pixel_row(32'h01010101, 1'b0, 1'b0, '0);
        add_cfg_row(CFG_IMAGE_WIDTH, 13'd0);
        add_pixel_row(32'hFFFFFFFF, 1'b0, 1'b0, '0);
        add_pixel_row(32'h00000000, 1'b0, 1'b0, '0);
        add_cfg_row(CFG_IMAGE_WIDTH, 13'h1FFF);
        add_pixel_row(32'h55AA55AA, 1'b0, 1'b0, '0);
        add_pixel_row(32'hAA55AA55, 1'b0, 1'b0, '0);
        add_cfg_row(CFG_IMAGE_WIDTH, 13'd2);
        add_pixel_row(32'h0F0F0F0F, 1'b0, 1'b0, '0);
        add_pixel_row(32'hF0F0F0F0, 1'b0, 1'b0, '0);
        add_pixel_row(32'h80000001, 1'b0, 1'b0, '0);
        add_cfg_row(CFG_DIRECTION, 13'd0);
        add_cfg_row(CFG_IMAGE_WIDTH, 13'd8);
        add_pixel_row(32'h11111111, 1'b1, 1'b0, '0);
        add_pixel_row(32'h22222222, 1'b0, 1'b0, '0);
        add_pixel_row(32'h33333333, 1'b0, 1'b0, '0);
        add_pixel_row(32'h44444444, 1'b0, 1'b0, '0);
        add_pixel_row(32'h55555555, 1'b0, 1'b0, '0);
        add_cfg_row(CFG_IMAGE_WIDTH, 13'd4);
        add_pixel_row(32'h66666666, 1'b0, 1'b0, '0);
        add_pixel_row(32'h77777777, 1'b0, 1'b0, '0);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[j]) begin
            row = directed_rows[j];
            if (row.is_cfg) begin
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_pixel(row.chans, row.chunk, row.typed, row.want);
            end
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == NUM_PHASES - 1) begin
                idle_on <= 1'b0;
            end else begin
                idle_on <= ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(CFG_DIRECTION, {12'($urandom), 1'($urandom)});
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(CFG_PIXEL_FORMAT, {12'($urandom), 1'($urandom)});
            end
            if (phase == BIG_PHASE) begin
                write_reg(CFG_IMAGE_WIDTH, 13'(MAX_WIDTH));
            end else if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 7))
                    0: write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(0, 3)));
                    1: write_reg(CFG_IMAGE_WIDTH, 13'd4);
                    2, 3: write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(5, 16)));
                    4, 5: write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(17, 64)));
                    6: write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(65, 300)));
                    default: write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(MAX_WIDTH, 8191)));
                endcase
            end
            n_items = $urandom_range(50, 170);
            for (i = 0; i < n_items; i++) begin
                for (k = 0; k < NUM_LANES; k++) begin
                    pick = $urandom_range(0, 9);
                    chans[k] = (pick == 0) ? 8'h00 : ((pick == 1) ? 8'hFF : 8'($urandom));
                end
                if (i == 0) begin
                    chunk = (phase == BIG_PHASE) || ($urandom_range(0, 1) == 1);
                end else begin
                    chunk = ($urandom_range(0, 63) == 0);
                end
                send_pixel(chans, chunk, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (err_count == 0 && expected_pixels.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/bgrd_pkg.sv
hdl/bgrd_lane.sv
hdl/bgrd_merge.sv
hdl/bgrd_line_buf.sv
hdl/bgr_decorrelate_2d_delta.sv
verif/tb_top.sv
